@@ rtl/core/bump_allocator_with_hole_reuse_macros.svh @@
// Assertion macros used by the allocator top module.
`ifndef BUMP_ALLOCATOR_WITH_HOLE_REUSE_MACROS_SVH
`define BUMP_ALLOCATOR_WITH_HOLE_REUSE_MACROS_SVH

`ifndef ASSERT_OFF
`define BA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define BA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define BA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/bmpalloc_pkg.sv @@
package bmpalloc_pkg;

	localparam int SIZE_W   = 16;
	localparam int SERIAL_W = 16;
	localparam int OFFSET_W = 15;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_RESTARTED = 2'd2;

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] request_size;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [SERIAL_W-1:0] block_number;
		logic [OFFSET_W-1:0] byte_offset;
		logic                opened_block;
		logic                from_hole;
	} rsp_t;

endpackage

@@ rtl/core/bump_allocator_with_hole_reuse.sv @@
// Bump allocator with reuse of the last 8-byte alignment hole.
// Request channel: req_valid / req_stall carrying req (command, request_size).
// A request with command alloc asks for request_size bytes; command restart
// drops the current heap but keeps the block serial count.
// Response channel: rsp_valid / rsp_stall carrying rsp (status, block_number,
// byte_offset, opened_block, from_hole), one response per request, in order.
// The request passes through two registers: the input register takes it when
// it is accepted, and the decision logic loads the response register from it
// once that register is empty or its response is taken; the allocator state
// is updated in the same cycle, and rsp_valid rises with that load.
// Throughput is one request per cycle while rsp_stall is low.
// When the receiver stalls, the response register holds its value and the
// input register keeps one more request; req_stall rises only once that
// register is also full.
// Reset clears both valid flags and empties the heap: block numbers restart
// so that the first block opened is number 1.
`include "bump_allocator_with_hole_reuse_macros.svh"

module bump_allocator_with_hole_reuse import bmpalloc_pkg::*; #(
	parameter int BLOCK_BYTES = 32768,
	parameter int HOLE_REACH  = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Fill point may reach the block end itself; the width leaves room for three bytes beyond it.
	localparam int FW = $clog2(BLOCK_BYTES + 4);

	logic                valid_s1;
	req_t                req_s1;
	logic                adv, load;

	logic [FW-1:0]       fill_q;
	logic [OFFSET_W-1:0] hole_off_q;
	logic                hole_v_q;
	logic                heap_open_q;
	logic [SERIAL_W-1:0] serial_q;

	rsp_t                rsp_d;
	logic [FW-1:0]       nxt_fill;
	logic [OFFSET_W-1:0] nxt_hole_off;
	logic                nxt_hole_v;
	logic                nxt_open;
	logic [SERIAL_W-1:0] nxt_serial;

	rsp_t                rsp_q;
	logic                rsp_valid_q;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign load      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	bmpalloc_calc #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.HOLE_REACH (HOLE_REACH),
		.FW         (FW)
	) u_calc (
		.req         (req_s1),
		.fill        (fill_q),
		.hole_off    (hole_off_q),
		.hole_v      (hole_v_q),
		.heap_open   (heap_open_q),
		.serial      (serial_q),
		.rsp         (rsp_d),
		.nxt_fill    (nxt_fill),
		.nxt_hole_off(nxt_hole_off),
		.nxt_hole_v  (nxt_hole_v),
		.nxt_open    (nxt_open),
		.nxt_serial  (nxt_serial)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			hole_off_q  <= '0;
			hole_v_q    <= 1'b0;
			heap_open_q <= 1'b0;
			serial_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				fill_q      <= nxt_fill;
				hole_off_q  <= nxt_hole_off;
				hole_v_q    <= nxt_hole_v;
				heap_open_q <= nxt_open;
				serial_q    <= nxt_serial;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	`BA_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, req_stall, valid_s1)
	`BA_ASSERT_IMPL(a_fill_word_aligned, clk, arst_n, 1'b1, fill_q[1:0] == 2'b00)
	`BA_ASSERT_NEXT(a_new_block_no_hole, clk, arst_n,
		load && rsp_d.opened_block, heap_open_q && !hole_v_q)
	`BA_ASSERT_NEXT(a_restart_closes_heap, clk, arst_n,
		load && req_s1.command == CMD_RESTART,
		!heap_open_q && rsp_valid && rsp.status == ST_RESTARTED)

endmodule

@@ rtl/core/bmpalloc_calc.sv @@
module bmpalloc_calc import bmpalloc_pkg::*; #(
	parameter int BLOCK_BYTES = 32768,
	parameter int HOLE_REACH  = 64,
	parameter int FW          = 16
) (
	input  req_t                req,
	input  logic [FW-1:0]       fill,
	input  logic [OFFSET_W-1:0] hole_off,
	input  logic                hole_v,
	input  logic                heap_open,
	input  logic [SERIAL_W-1:0] serial,
	output rsp_t                rsp,
	output logic [FW-1:0]       nxt_fill,
	output logic [OFFSET_W-1:0] nxt_hole_off,
	output logic                nxt_hole_v,
	output logic                nxt_open,
	output logic [SERIAL_W-1:0] nxt_serial
);

	// Common compare width: holds the block size, a rounded size and the fill point.
	localparam int CW = ((FW > SIZE_W + 1) ? FW : SIZE_W + 1) + 1;

	logic [CW-1:0] size_w, sz_w, fill_w, hole_w, blk_w, base_w, off_w, end_w;
	logic          too_large, is4, reuse, fits, open_new, align;

	always_comb begin
		size_w    = CW'(req.request_size);
		sz_w      = (size_w + CW'(3)) & ~CW'(3);
		fill_w    = CW'(fill);
		hole_w    = CW'(hole_off);
		blk_w     = CW'(BLOCK_BYTES);
		too_large = size_w > blk_w;
		is4       = sz_w == CW'(4);

		// The hole only ever holds 4 bytes, since the fill point is always word aligned.
		reuse = heap_open && hole_v && is4 && (fill_w >= hole_w) &&
			((fill_w - hole_w) <= CW'(HOLE_REACH));
		fits  = heap_open && (fill_w < blk_w) && ((blk_w - fill_w) > sz_w);
		open_new = !reuse && !fits;

		base_w = open_new ? '0 : fill_w;
		align  = !is4 && base_w[2];
		off_w  = align ? base_w + CW'(4) : base_w;
		end_w  = off_w + sz_w;

		nxt_fill     = fill;
		nxt_hole_off = hole_off;
		nxt_hole_v   = hole_v;
		nxt_open     = heap_open;
		nxt_serial   = serial;

		rsp = '0;

		if (req.command == CMD_RESTART) begin
			rsp.status = ST_RESTARTED;
			nxt_open   = 1'b0;
		end else if (too_large) begin
			rsp.status = ST_TOO_LARGE;
		end else if (reuse) begin
			rsp.status       = ST_ALLOCATED;
			rsp.block_number = serial;
			rsp.byte_offset  = hole_off;
			rsp.from_hole    = 1'b1;
			nxt_hole_v       = 1'b0;
		end else begin
			if (open_new) begin
				nxt_serial = serial + SERIAL_W'(1);
				nxt_open   = 1'b1;
				nxt_hole_v = 1'b0;
			end
			if (align) begin
				nxt_hole_v   = 1'b1;
				nxt_hole_off = base_w[OFFSET_W-1:0];
			end
			nxt_fill         = end_w[FW-1:0];
			rsp.status       = ST_ALLOCATED;
			rsp.block_number = open_new ? serial + SERIAL_W'(1) : serial;
			rsp.byte_offset  = off_w[OFFSET_W-1:0];
			rsp.opened_block = open_new;
		end
	end

endmodule

@@ tb/sv/bump_allocator_with_hole_reuse_tb.sv @@
`timescale 1ns / 1ps

module bump_allocator_with_hole_reuse_tb;
	import bmpalloc_pkg::*;

	localparam int BLOCK_BYTES     = 32768;
	localparam int HOLE_REACH      = 64;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_REQUESTS = 1750;

	// Shadow copy of the heap: works out the grant for every accepted request.
	class heap_shadow;
		logic [15:0] fill_offset;
		logic [14:0] hole_offset;
		logic [3:0]  hole_length;
		logic        heap_open;
		logic [15:0] block_serial;
		rsp_t        pending_grants[$];
		int          mismatches;

		function new();
			fill_offset  = '0;
			hole_offset  = '0;
			hole_length  = '0;
			heap_open    = 1'b0;
			block_serial = '0;
			mismatches   = 0;
		endfunction

		// Anything but a single word is aligned to 8 bytes; the skipped word
		// becomes the pending hole.
		function logic [14:0] bump(int unsigned rounded);
			int unsigned fill;
			int unsigned at;
			fill = fill_offset;
			at   = fill;
			if (rounded != 4 && (fill % 8) != 0) begin
				hole_length = 4'(8 - fill % 8);
				hole_offset = 15'(fill);
				at          = fill + 8 - fill % 8;
			end
			fill_offset = 16'(at + rounded);
			return 15'(at);
		endfunction

		function void take_request(req_t r);
			rsp_t        grant;
			int unsigned rounded;
			int unsigned fill;
			logic        placed;
			grant = '0;
			if (r.command == CMD_RESTART) begin
				heap_open    = 1'b0;
				grant.status = ST_RESTARTED;
			end else if (r.request_size > BLOCK_BYTES) begin
				grant.status = ST_TOO_LARGE;
			end else begin
				rounded = (r.request_size + 32'd3) & ~32'd3;
				fill    = fill_offset;
				placed  = 1'b0;
				if (heap_open) begin
					if (hole_length != 0 && hole_length == rounded &&
					    fill >= hole_offset && fill - hole_offset <= HOLE_REACH) begin
						hole_length       = '0;
						grant.byte_offset = hole_offset;
						grant.from_hole   = 1'b1;
						placed            = 1'b1;
					end else if (fill < BLOCK_BYTES && BLOCK_BYTES - fill > rounded) begin
						grant.byte_offset = bump(rounded);
						placed            = 1'b1;
					end
				end
				if (!placed) begin
					block_serial       = block_serial + 16'd1;
					fill_offset        = '0;
					hole_length        = '0;
					heap_open          = 1'b1;
					grant.opened_block = 1'b1;
					grant.byte_offset  = bump(rounded);
				end
				grant.status       = ST_ALLOCATED;
				grant.block_number = block_serial;
			end
			pending_grants.push_back(grant);
		endfunction

		function void match_response(rsp_t got);
			rsp_t want;
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected response %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_grants.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
				mismatches++;
			end
			if (got.block_number !== want.block_number) begin
				$display("%0t: block_number expected %0d got %0d", $time,
					want.block_number, got.block_number);
				mismatches++;
			end
			if (got.byte_offset !== want.byte_offset) begin
				$display("%0t: byte_offset expected %0d got %0d", $time,
					want.byte_offset, got.byte_offset);
				mismatches++;
			end
			if (got.opened_block !== want.opened_block) begin
				$display("%0t: opened_block expected %0d got %0d", $time,
					want.opened_block, got.opened_block);
				mismatches++;
			end
			if (got.from_hole !== want.from_hole) begin
				$display("%0t: from_hole expected %0d got %0d", $time,
					want.from_hole, got.from_hole);
				mismatches++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	heap_shadow shadow = new();
	bit         idling = 1'b1;
	int         cycles = 0;
	int         stall_left = 0;

	bump_allocator_with_hole_reuse #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.HOLE_REACH (HOLE_REACH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bump_allocator_with_hole_reuse regression: fail");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one, none while idling is off.
	function automatic int pick_pause();
		int p;
		if (!idling)
			return 0;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic req_t make_req(logic c, int unsigned s);
		req_t r;
		r.command      = c;
		r.request_size = 16'(s);
		return r;
	endfunction

	function automatic req_t random_request();
		int p;
		p = $urandom_range(99);
		if (p < 3)
			return make_req(CMD_RESTART, $urandom);
		if (p < 8)
			return make_req(CMD_ALLOC, $urandom_range(65535, BLOCK_BYTES + 1));
		if (p < 40)
			return make_req(CMD_ALLOC, $urandom_range(4, 0));
		if (p < 75)
			return make_req(CMD_ALLOC, $urandom_range(64, 5));
		if (p < 93)
			return make_req(CMD_ALLOC, $urandom_range(2048, 65));
		return make_req(CMD_ALLOC, $urandom_range(BLOCK_BYTES, 2049));
	endfunction

	// Receiver side: check each accepted response, then choose the next stall.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			shadow.match_response(rsp);
		if (stall_left == 0)
			stall_left = pick_pause();
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_request(input req_t r);
		int gap;
		gap = pick_pause();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		shadow.take_request(r);
	endtask

	initial begin
		req_t directed[$];
		int   sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hole creation and reuse, sizes that round up, exact fill of a block,
		// oversize requests, restarts, and the reach limit on both sides.
		directed.push_back(make_req(CMD_ALLOC, 0));
		directed.push_back(make_req(CMD_ALLOC, 4));
		directed.push_back(make_req(CMD_ALLOC, 8));
		directed.push_back(make_req(CMD_ALLOC, 3));
		directed.push_back(make_req(CMD_ALLOC, 1));
		directed.push_back(make_req(CMD_ALLOC, 5));
		directed.push_back(make_req(CMD_ALLOC, BLOCK_BYTES));
		directed.push_back(make_req(CMD_ALLOC, BLOCK_BYTES + 1));
		directed.push_back(make_req(CMD_ALLOC, 65535));
		directed.push_back(make_req(CMD_ALLOC, 2));
		directed.push_back(make_req(CMD_RESTART, 65535));
		directed.push_back(make_req(CMD_ALLOC, BLOCK_BYTES - 1));
		directed.push_back(make_req(CMD_RESTART, 0));
		directed.push_back(make_req(CMD_ALLOC, 4));
		directed.push_back(make_req(CMD_ALLOC, 8));
		directed.push_back(make_req(CMD_ALLOC, 52));
		directed.push_back(make_req(CMD_ALLOC, 4));
		directed.push_back(make_req(CMD_ALLOC, 8));
		directed.push_back(make_req(CMD_ALLOC, 56));
		directed.push_back(make_req(CMD_ALLOC, 4));
		directed.push_back(make_req(CMD_ALLOC, 16384));
		directed.push_back(make_req(CMD_ALLOC, 16240));
		directed.push_back(make_req(CMD_ALLOC, 16528));
		directed.push_back(make_req(CMD_ALLOC, 16236));
		foreach (directed[i])
			send_request(directed[i]);

		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			if ($urandom_range(199) == 0)
				idling = ~idling;
			if ($urandom_range(3) == 0) begin
				// A word, then an aligned request that may leave a hole, then some
				// filler and a word that may land in the hole.
				send_request(make_req(CMD_ALLOC, 4));
				send_request(make_req(CMD_ALLOC, $urandom_range(64, 5)));
				send_request(make_req(CMD_ALLOC, $urandom_range(60, 0)));
				send_request(make_req(CMD_ALLOC, $urandom_range(4, 1)));
				sent += 4;
			end else begin
				send_request(random_request());
				sent++;
			end
		end
		req_valid <= 1'b0;
		idling = 1'b0;

		while (shadow.pending_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("bump_allocator_with_hole_reuse regression: pass");
		else
			$display("bump_allocator_with_hole_reuse regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bmpalloc_pkg.sv
rtl/core/bmpalloc_calc.sv
rtl/core/bump_allocator_with_hole_reuse.sv
tb/sv/bump_allocator_with_hole_reuse_tb.sv
